// ----- rtl/prq_pkg.sv -----
// prq_pkg: field widths, command and status codes, entry type and the
// controller/datapath command and status structs of the priority ready queue
// no dependencies
`default_nettype none

package prq_pkg;

  localparam int CMD_W    = 2;
  localparam int ID_W     = 6;
  localparam int PRIO_W   = 8;
  localparam int STATUS_W = 2;
  localparam int OCC_W    = 7;

  typedef logic [CMD_W-1:0]    cmd_t;
  typedef logic [ID_W-1:0]     id_t;
  typedef logic [PRIO_W-1:0]   prio_t;
  typedef logic [STATUS_W-1:0] status_t;
  typedef logic [OCC_W-1:0]    occ_t;

  localparam cmd_t CMD_INSERT = 2'd0;
  localparam cmd_t CMD_POP    = 2'd1;
  localparam cmd_t CMD_REMOVE = 2'd2;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_MISSING = 2'd1;
  localparam status_t ST_FULL    = 2'd2;

  localparam occ_t OCC_MAX = '1;

  typedef struct packed {
    id_t   id;
    prio_t prio;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_INS_RD,
    S_INS_CHK,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_SHF_RD,
    S_SHF_WR
  } state_t;

  typedef enum logic [2:0] {
    IDX_HOLD,
    IDX_ZERO,
    IDX_COUNT,
    IDX_INC,
    IDX_DEC
  } idx_op_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC
  } cnt_op_t;

  typedef enum logic [1:0] {
    RD_PREV,
    RD_CUR,
    RD_NEXT
  } rd_mode_t;

  typedef enum logic {
    WR_NEW,
    WR_MOVED
  } wr_mode_t;

  // controller -> datapath
  typedef struct packed {
    logic     ld_in;
    idx_op_t  idx_op;
    cnt_op_t  cnt_op;
    logic     rd_en;
    rd_mode_t rd_mode;
    logic     wr_en;
    wr_mode_t wr_mode;
    logic     cap_hit;
    logic     set_status;
    status_t  status_val;
    logic     res_ld;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    cmd_t cmd;
    logic count_full;
    logic idx_zero;
    logic idx_at_count;
    logic next_at_end;
    logic prio_gt;
    logic id_match;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ----- rtl/prq_if.sv -----
// prq_in_if / prq_out_if: valid/ready channels for command items and result items
// depends on prq_pkg
`default_nettype none

interface prq_in_if;
  import prq_pkg::*;

  logic  valid;
  logic  ready;
  cmd_t  cmd;
  id_t   thread_id;
  prio_t prio;

  modport source (output valid, output cmd, output thread_id, output prio, input ready);
  modport sink   (input valid, input cmd, input thread_id, input prio, output ready);
endinterface

interface prq_out_if;
  import prq_pkg::*;

  logic    valid;
  logic    ready;
  status_t status;
  id_t     out_id;
  prio_t   out_prio;
  occ_t    occupancy;

  modport source (output valid, output status, output out_id, output out_prio,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_id, input out_prio,
                  input occupancy, output ready);
endinterface

`default_nettype wire

// ----- rtl/prq_ctrl.sv -----
// prq_ctrl: sequencer for insert, pop and remove-by-id over the sorted store
// depends on prq_pkg
`default_nettype none

module prq_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  prq_pkg::stat_t stat,
  output prq_pkg::ctrl_t ctrl
);
  import prq_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    ctrl.ld_in      = 1'b0;
    ctrl.idx_op     = IDX_HOLD;
    ctrl.cnt_op     = CNT_HOLD;
    ctrl.rd_en      = 1'b0;
    ctrl.rd_mode    = RD_CUR;
    ctrl.wr_en      = 1'b0;
    ctrl.wr_mode    = WR_NEW;
    ctrl.cap_hit    = 1'b0;
    ctrl.set_status = 1'b0;
    ctrl.status_val = ST_OK;
    ctrl.res_ld     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        ctrl.ld_in = in_valid;
        if (in_valid) begin
          state_nxt = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        priority if (stat.cmd == CMD_INSERT) begin
          if (stat.count_full) begin
            ctrl.set_status = 1'b1;
            ctrl.status_val = ST_FULL;
            state_nxt       = S_IDLE;
            ctrl.res_ld     = stat.out_free;
            if (!stat.out_free) state_nxt = S_DISPATCH;
          end else begin
            ctrl.idx_op = IDX_COUNT;
            state_nxt   = S_INS_RD;
          end
        end else if (stat.cmd == CMD_POP || stat.cmd == CMD_REMOVE) begin
          ctrl.idx_op = IDX_ZERO;
          state_nxt   = S_SRCH_RD;
        end else begin
          // unused code: plain no-op result
          ctrl.res_ld = stat.out_free;
          state_nxt   = stat.out_free ? S_IDLE : S_DISPATCH;
        end
      end

      S_INS_RD: begin
        if (stat.idx_zero) begin
          ctrl.wr_en   = 1'b1;
          ctrl.wr_mode = WR_NEW;
          ctrl.cnt_op  = CNT_INC;
          state_nxt    = S_SHF_RD;
          // reuse the shift-done exit: it reports once the output slot is free
          ctrl.idx_op  = IDX_COUNT;
        end else begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_mode = RD_PREV;
          state_nxt    = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        ctrl.wr_en = 1'b1;
        if (stat.prio_gt) begin
          ctrl.wr_mode = WR_MOVED;
          ctrl.idx_op  = IDX_DEC;
          state_nxt    = S_INS_RD;
        end else begin
          ctrl.wr_mode = WR_NEW;
          ctrl.cnt_op  = CNT_INC;
          ctrl.idx_op  = IDX_COUNT;
          state_nxt    = S_SHF_RD;
        end
      end

      S_SRCH_RD: begin
        if (stat.idx_at_count) begin
          // empty pop or id not found
          ctrl.set_status = 1'b1;
          ctrl.status_val = ST_MISSING;
          ctrl.res_ld     = stat.out_free;
          state_nxt       = stat.out_free ? S_IDLE : S_SRCH_RD;
        end else begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_mode = RD_CUR;
          state_nxt    = S_SRCH_CHK;
        end
      end

      S_SRCH_CHK: begin
        if (stat.cmd == CMD_POP || stat.id_match) begin
          ctrl.cap_hit = 1'b1;
          state_nxt    = S_SHF_RD;
        end else begin
          ctrl.idx_op = IDX_INC;
          state_nxt   = S_SRCH_RD;
        end
      end

      S_SHF_RD: begin
        if (stat.next_at_end) begin
          // close the gap left by a removal, or finish an insert
          ctrl.res_ld = stat.out_free;
          if (stat.out_free) begin
            state_nxt = S_IDLE;
            if (stat.cmd != CMD_INSERT) begin
              ctrl.cnt_op = CNT_DEC;
            end
          end
        end else begin
          ctrl.rd_en   = 1'b1;
          ctrl.rd_mode = RD_NEXT;
          state_nxt    = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        ctrl.wr_en   = 1'b1;
        ctrl.wr_mode = WR_MOVED;
        ctrl.idx_op  = IDX_INC;
        state_nxt    = S_SHF_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/prq_datapath.sv -----
// prq_datapath: entry memory, count and index registers, captured command and
// result registers, output register; depends on prq_pkg
`default_nettype none

module prq_datapath #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  prq_pkg::ctrl_t    ctrl,
  output prq_pkg::stat_t    stat,
  input  prq_pkg::cmd_t     in_cmd,
  input  prq_pkg::id_t      in_thread_id,
  input  prq_pkg::prio_t    in_prio,
  output logic              out_valid,
  input  logic              out_ready,
  output prq_pkg::status_t  out_status,
  output prq_pkg::id_t      out_id,
  output prq_pkg::prio_t    out_prio,
  output prq_pkg::occ_t     out_occupancy
);
  import prq_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int EW = CW + OCC_W + 1;

  entry_t mem [QUEUE_DEPTH];

  cmd_t    cmd_r;
  id_t     id_r;
  prio_t   prio_r;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] count_r, count_nxt;
  entry_t  rdata_r;
  status_t res_status_r;
  id_t     res_id_r;
  prio_t   res_prio_r;

  logic    out_valid_r;
  status_t out_status_r;
  id_t     out_id_r;
  prio_t   out_prio_r;
  occ_t    out_occ_r;

  logic [CW-1:0] idx_prev, idx_next;
  logic [AW-1:0] rd_addr;
  entry_t        wr_data;
  logic [EW-1:0] count_ext;
  occ_t          occ_sat;

  assign idx_prev = idx_r - CW'(1);
  assign idx_next = idx_r + CW'(1);

  always_comb begin
    unique case (ctrl.rd_mode)
      RD_PREV: rd_addr = idx_prev[AW-1:0];
      RD_NEXT: rd_addr = idx_next[AW-1:0];
      default: rd_addr = idx_r[AW-1:0];
    endcase
  end

  assign wr_data = (ctrl.wr_mode == WR_MOVED) ? rdata_r : entry_t'{id: id_r, prio: prio_r};

  // store: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[idx_r[AW-1:0]] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_comb begin
    unique case (ctrl.idx_op)
      IDX_ZERO:  idx_nxt = '0;
      IDX_COUNT: idx_nxt = count_r;
      IDX_INC:   idx_nxt = idx_next;
      IDX_DEC:   idx_nxt = idx_prev;
      default:   idx_nxt = idx_r;
    endcase
  end

  always_comb begin
    unique case (ctrl.cnt_op)
      CNT_INC: count_nxt = count_r + CW'(1);
      CNT_DEC: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    if (ctrl.ld_in) begin
      cmd_r        <= in_cmd;
      id_r         <= in_thread_id;
      prio_r       <= in_prio;
      res_status_r <= ST_OK;
      res_id_r     <= '0;
      res_prio_r   <= '0;
    end else begin
      if (ctrl.set_status) begin
        res_status_r <= ctrl.status_val;
      end
      if (ctrl.cap_hit) begin
        res_id_r   <= rdata_r.id;
        res_prio_r <= rdata_r.prio;
      end
    end
  end

  // occupancy field saturates when the depth exceeds its range
  assign count_ext = EW'(count_nxt);
  assign occ_sat   = (count_ext > EW'(OCC_MAX)) ? OCC_MAX : count_ext[OCC_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.res_ld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.res_ld) begin
      out_status_r <= ctrl.set_status ? ctrl.status_val : res_status_r;
      out_id_r     <= res_id_r;
      out_prio_r   <= res_prio_r;
      out_occ_r    <= occ_sat;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_id        = out_id_r;
  assign out_prio      = out_prio_r;
  assign out_occupancy = out_occ_r;

  assign stat.cmd          = cmd_r;
  assign stat.count_full   = (count_r == CW'(QUEUE_DEPTH));
  assign stat.idx_zero     = (idx_r == '0);
  assign stat.idx_at_count = (idx_r == count_r);
  assign stat.next_at_end  = ({1'b0, idx_r} + (CW + 1)'(1)) >= {1'b0, count_r};
  assign stat.prio_gt      = (rdata_r.prio > prio_r);
  assign stat.id_match     = (rdata_r.id == id_r);
  assign stat.out_free     = !out_valid_r || out_ready;

endmodule

`default_nettype wire

// ----- rtl/priority_ready_queue.sv -----
// priority_ready_queue: stable priority queue with pop and remove-by-id
// depends on prq_pkg, prq_if, prq_ctrl, prq_datapath
//
// operation: insert moves each entry with a higher priority value down one slot
//   before writing the new one; pop shifts the remaining entries up; remove scans
//   for the id, then shifts the entries behind it up; a full insert, an empty pop
//   and a no-op touch no entry; an absent id is reported after a full scan
// throughput: one item in flight; in ready is high only in idle, the state entered
//   once the result is loaded; the result register lets the next item in while the
//   previous result waits
// reset: synchronous active-low rst_n empties the queue and drops a pending result;
//   the entry memory is not cleared (only entries below the count are read)
`default_nettype none

module priority_ready_queue #(
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  prq_in_if.sink     in_ch,
  prq_out_if.source  out_ch
);
  import prq_pkg::*;

  ctrl_t ctrl;
  stat_t stat;
  logic  in_ready;

  // sequencer: chooses addresses, writes and count updates per step
  prq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  assign in_ch.ready = in_ready;

  // sorted store kept in ascending priority, ties in arrival order
  prq_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctrl          (ctrl),
    .stat          (stat),
    .in_cmd        (in_ch.cmd),
    .in_thread_id  (in_ch.thread_id),
    .in_prio       (in_ch.prio),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_status    (out_ch.status),
    .out_id        (out_ch.out_id),
    .out_prio      (out_ch.out_prio),
    .out_occupancy (out_ch.occupancy)
  );

endmodule

`default_nettype wire
